// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion helpers shared by the touch qualifier rtl
// all macros sample on clk and are disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every edge
`define TSQM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define TSQM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSQM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tsqm_pkg.sv -----
// ---------------------------------------------------------------------------
// tsqm_pkg
// types, constants and codes shared by the touch sample qualifier and mapper
// ---------------------------------------------------------------------------
package tsqm_pkg;

  // block sizing
  localparam int RING_DEPTH  = 6;
  localparam int MAX_RETRIES = 40;
  localparam int SAMPLE_BITS = 12;

  // field widths fixed by the interface
  localparam int REQ_W   = 2;
  localparam int SMP_W   = 12;
  localparam int POS_W   = 12;
  localparam int TOL_W   = 12;
  localparam int PIX_W   = 13;
  localparam int GAIN_W  = 16;
  localparam int OFF_W   = 16;
  localparam int ORIENT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // derived ring widths
  localparam int IDX_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int RETRY_W = $clog2(MAX_RETRIES + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(RING_DEPTH);
  localparam int CMP_W   = (SAMPLE_BITS > TOL_W) ? SAMPLE_BITS : TOL_W;

  // average by reciprocal multiply: ceil(2^k / depth), k is the sum width plus 4
  localparam int DIV_SHIFT = SUM_W + 4;
  localparam int RECIP_W   = DIV_SHIFT - $clog2(RING_DEPTH) + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + RING_DEPTH - 1) / RING_DEPTH);

  // signed width for scaled minus offset
  localparam int MAP_W = ((SAMPLE_BITS > OFF_W) ? SAMPLE_BITS : OFF_W) + 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CONFIRM = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_XSCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YSCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_XOFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_YOFF   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 3'd7;

  // register reset values
  localparam logic [ORIENT_W-1:0] ORIENT_RST = 3'd0;
  localparam logic [PIX_W-1:0]    WIDTH_RST  = 13'd320;
  localparam logic [PIX_W-1:0]    HEIGHT_RST = 13'd240;
  localparam logic [GAIN_W-1:0]   XSCALE_RST = 16'd5104;
  localparam logic [GAIN_W-1:0]   YSCALE_RST = 16'd3824;
  localparam logic [OFF_W-1:0]    XOFF_RST   = 16'd0;
  localparam logic [OFF_W-1:0]    YOFF_RST   = 16'd0;
  localparam logic [TOL_W-1:0]    TOL_RST    = 12'd70;

  // sequencing phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_X       = 4'b0010,
    PH_Y       = 4'b0100,
    PH_CONFIRM = 4'b1000
  } phase_t;

  // controls from the sequencer to the ring
  typedef struct packed {
    logic                   clear;
    logic                   step;
    logic [SAMPLE_BITS-1:0] smp;
  } ring_ctl_t;

  // what the ring reports for the sample now offered
  typedef struct packed {
    logic                   pass;
    logic                   limit;
    logic [SAMPLE_BITS-1:0] avg;
  } ring_stat_t;

endpackage

// ----- hdl/tsqm_ring_qual.sv -----
// ---------------------------------------------------------------------------
// tsqm_ring_qual
// sample ring with running sum, average and tolerance check for one axis
// ---------------------------------------------------------------------------
module tsqm_ring_qual (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tsqm_pkg::ring_ctl_t           ctl,
  input  logic [tsqm_pkg::TOL_W-1:0]    tolerance,
  output tsqm_pkg::ring_stat_t          stat
);

  logic [tsqm_pkg::SAMPLE_BITS-1:0] entry_r [tsqm_pkg::RING_DEPTH];
  logic [tsqm_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [tsqm_pkg::FILL_W-1:0]      fill_r;
  logic [tsqm_pkg::RETRY_W-1:0]     retry_r, retry_nxt;
  logic [tsqm_pkg::IDX_W-1:0]       slot_r, slot_sel, wr_idx, first_bad;

  logic                             full, limit, check;
  logic [tsqm_pkg::SUM_W-1:0]       sum_base;
  logic [tsqm_pkg::SAMPLE_BITS-1:0] entry_new [tsqm_pkg::RING_DEPTH];
  logic [tsqm_pkg::SUM_W+tsqm_pkg::RECIP_W-1:0] prod;
  logic [tsqm_pkg::SAMPLE_BITS-1:0] avg;
  logic [tsqm_pkg::RING_DEPTH-1:0]  offend;

  // slot that the next sample lands in
  always_comb begin
    full     = (fill_r == tsqm_pkg::FILL_W'(tsqm_pkg::RING_DEPTH));
    slot_sel = ({1'b0, slot_r} < (tsqm_pkg::IDX_W+1)'(tsqm_pkg::RING_DEPTH)) ? slot_r : '0;
    wr_idx   = full ? slot_sel : fill_r[tsqm_pkg::IDX_W-1:0];
  end

  // running sum and retry count after this sample
  always_comb begin
    sum_base  = full ? (sum_r - tsqm_pkg::SUM_W'(entry_r[slot_sel])) : sum_r;
    sum_nxt   = sum_base + tsqm_pkg::SUM_W'(ctl.smp);
    retry_nxt = retry_r + tsqm_pkg::RETRY_W'(1);
    limit     = full && (retry_nxt >= tsqm_pkg::RETRY_W'(tsqm_pkg::MAX_RETRIES));
    check     = full ? !limit
                     : (fill_r == tsqm_pkg::FILL_W'(tsqm_pkg::RING_DEPTH - 1));
  end

  // ring contents as they will be after the write
  always_comb begin
    for (int i = 0; i < tsqm_pkg::RING_DEPTH; i++) begin
      entry_new[i] = (wr_idx == tsqm_pkg::IDX_W'(i)) ? ctl.smp : entry_r[i];
    end
  end

  // truncated average by reciprocal multiply
  always_comb begin
    prod = tsqm_pkg::SUM_W'(sum_nxt) * tsqm_pkg::RECIP;
    avg  = tsqm_pkg::SAMPLE_BITS'(prod >> tsqm_pkg::DIV_SHIFT);
  end

  // distance of each entry from the average, first offender wins
  always_comb begin
    logic [tsqm_pkg::SAMPLE_BITS-1:0] d;
    first_bad = '0;
    for (int i = 0; i < tsqm_pkg::RING_DEPTH; i++) begin
      d = (entry_new[i] > avg) ? (entry_new[i] - avg) : (avg - entry_new[i]);
      offend[i] = (tsqm_pkg::CMP_W'(d) > tsqm_pkg::CMP_W'(tolerance));
    end
    for (int i = tsqm_pkg::RING_DEPTH - 1; i >= 0; i--) begin
      if (offend[i]) first_bad = tsqm_pkg::IDX_W'(i);
    end
  end

  always_comb begin
    stat.pass  = check && !(|offend);
    stat.limit = limit;
    stat.avg   = avg;
  end

  // ring storage, written by every sample step
  always_ff @(posedge clk) begin
    if (ctl.step) entry_r[wr_idx] <= ctl.smp;
  end

  // ring bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      fill_r  <= '0;
      retry_r <= '0;
      slot_r  <= '0;
    end else if (ctl.clear || (ctl.step && stat.pass)) begin
      sum_r   <= '0;
      fill_r  <= '0;
      retry_r <= '0;
      slot_r  <= '0;
    end else if (ctl.step) begin
      sum_r <= sum_nxt;
      if (!full) fill_r <= fill_r + tsqm_pkg::FILL_W'(1);
      else retry_r <= retry_nxt;
      if (check && (|offend)) slot_r <= first_bad;
    end
  end

endmodule

// ----- hdl/tsqm_axis_map.sv -----
// ---------------------------------------------------------------------------
// tsqm_axis_map
// scale, offset and clamp of one raw axis value to a pixel coordinate
// ---------------------------------------------------------------------------
module tsqm_axis_map (
  input  logic [tsqm_pkg::SAMPLE_BITS-1:0] raw,
  input  logic [tsqm_pkg::GAIN_W-1:0]      scale,
  input  logic signed [tsqm_pkg::OFF_W-1:0] offset,
  input  logic [tsqm_pkg::PIX_W-1:0]       pixels,
  output logic [tsqm_pkg::POS_W-1:0]       pos
);

  logic [tsqm_pkg::SAMPLE_BITS+tsqm_pkg::GAIN_W-1:0] prod;
  logic [tsqm_pkg::SAMPLE_BITS-1:0]        scaled;
  logic signed [tsqm_pkg::MAP_W-1:0]       sc_ext, off_ext, coord, lim_ext;
  logic [tsqm_pkg::PIX_W-1:0]              pix_m1;
  logic [tsqm_pkg::POS_W-1:0]              lim;

  // gain with 16 fractional bits, then offset in signed wide form
  always_comb begin
    prod    = (tsqm_pkg::SAMPLE_BITS+tsqm_pkg::GAIN_W)'(raw) *
              (tsqm_pkg::SAMPLE_BITS+tsqm_pkg::GAIN_W)'(scale);
    scaled  = prod[tsqm_pkg::SAMPLE_BITS+tsqm_pkg::GAIN_W-1:tsqm_pkg::GAIN_W];
    sc_ext  = tsqm_pkg::MAP_W'(scaled);
    off_ext = tsqm_pkg::MAP_W'(offset);
    coord   = sc_ext - off_ext;
  end

  // clamp limit: pixels - 1, zero for an empty display, saturated to the field
  always_comb begin
    pix_m1 = pixels - tsqm_pkg::PIX_W'(1);
    if (pixels == '0) lim = '0;
    else if (pix_m1 > tsqm_pkg::PIX_W'(tsqm_pkg::POS_MAX)) lim = tsqm_pkg::POS_MAX;
    else lim = pix_m1[tsqm_pkg::POS_W-1:0];
    lim_ext = tsqm_pkg::MAP_W'(lim);
  end

  always_comb begin
    if (coord < 0) pos = '0;
    else if (coord > lim_ext) pos = lim;
    else pos = coord[tsqm_pkg::POS_W-1:0];
  end

endmodule

// ----- hdl/touch_sample_qualify_and_map.sv -----
// ---------------------------------------------------------------------------
// touch_sample_qualify_and_map
// qualifies touch converter samples per axis and maps the result to pixels
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | req_type, pen_down, sample
//  out_    | output    | out_valid / out_ready| touched, x_pos, y_pos, raw_x, raw_y
//  cfg_    | input     | cfg_valid / cfg_ready| index, data (8 registers)
//
//  one item per cycle unless a waiting result stalls it: each item is held in
//  the input register, and its result enters the output register as the item fires
//  the per-item path is the ring sum update, the reciprocal multiply for the
//  average and the six tolerance compares
//  synchronous active-low reset, no clearing pass; cfg_ready is always high
//  a waiting result stalls only items that produce a result; one more item
//  is held in the input register while the output waits
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_sample_qualify_and_map (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tsqm_pkg::REQ_W-1:0]         in_req_type,
  input  logic                               in_pen_down,
  input  logic [tsqm_pkg::SMP_W-1:0]         in_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_touched,
  output logic [tsqm_pkg::POS_W-1:0]         out_x_pos,
  output logic [tsqm_pkg::POS_W-1:0]         out_y_pos,
  output logic [tsqm_pkg::POS_W-1:0]         out_raw_x,
  output logic [tsqm_pkg::POS_W-1:0]         out_raw_y,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsqm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsqm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [tsqm_pkg::ORIENT_W-1:0] orient_r;
  logic [tsqm_pkg::PIX_W-1:0]    width_r, height_r;
  logic [tsqm_pkg::GAIN_W-1:0]   xscale_r, yscale_r;
  logic signed [tsqm_pkg::OFF_W-1:0] xoff_r, yoff_r;
  logic [tsqm_pkg::TOL_W-1:0]    tol_r;

  // input register
  logic                          in_v_r;
  logic [tsqm_pkg::REQ_W-1:0]    req_r;
  logic                          pen_r;
  logic [tsqm_pkg::SMP_W-1:0]    smp_r;

  // sequencing state
  tsqm_pkg::phase_t              phase_r, phase_nxt;
  logic [tsqm_pkg::SAMPLE_BITS-1:0] xavg_r, yavg_r;

  // output register
  logic                          out_v_r;
  logic                          touched_nxt;
  logic [tsqm_pkg::POS_W-1:0]    xpos_nxt, ypos_nxt, rawx_nxt, rawy_nxt;
  logic                          touched_r;
  logic [tsqm_pkg::POS_W-1:0]    xpos_r, ypos_r, rawx_r, rawy_r;

  logic                          is_start, is_sample, is_confirm, in_axis;
  logic                          has_result, fire, map_ok;
  tsqm_pkg::ring_ctl_t           ring_ctl;
  tsqm_pkg::ring_stat_t          ring_stat;
  logic [tsqm_pkg::SAMPLE_BITS-1:0] vx_sw, vy_sw, vx, vy;
  logic [tsqm_pkg::POS_W-1:0]    xpos_map, ypos_map;

  // configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= tsqm_pkg::ORIENT_RST;
      width_r  <= tsqm_pkg::WIDTH_RST;
      height_r <= tsqm_pkg::HEIGHT_RST;
      xscale_r <= tsqm_pkg::XSCALE_RST;
      yscale_r <= tsqm_pkg::YSCALE_RST;
      xoff_r   <= tsqm_pkg::XOFF_RST;
      yoff_r   <= tsqm_pkg::YOFF_RST;
      tol_r    <= tsqm_pkg::TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsqm_pkg::CFG_ORIENT: orient_r <= cfg_data[tsqm_pkg::ORIENT_W-1:0];
        tsqm_pkg::CFG_WIDTH:  width_r  <= cfg_data[tsqm_pkg::PIX_W-1:0];
        tsqm_pkg::CFG_HEIGHT: height_r <= cfg_data[tsqm_pkg::PIX_W-1:0];
        tsqm_pkg::CFG_XSCALE: xscale_r <= cfg_data;
        tsqm_pkg::CFG_YSCALE: yscale_r <= cfg_data;
        tsqm_pkg::CFG_XOFF:   xoff_r   <= cfg_data;
        tsqm_pkg::CFG_YOFF:   yoff_r   <= cfg_data;
        tsqm_pkg::CFG_TOL:    tol_r    <= cfg_data[tsqm_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // decode of the registered item
  always_comb begin
    is_start   = (req_r == tsqm_pkg::REQ_START);
    is_sample  = (req_r == tsqm_pkg::REQ_SAMPLE);
    is_confirm = (req_r == tsqm_pkg::REQ_CONFIRM) && (phase_r == tsqm_pkg::PH_CONFIRM);
    in_axis    = (phase_r == tsqm_pkg::PH_X) || (phase_r == tsqm_pkg::PH_Y);
    has_result = (is_start && !pen_r) || (is_sample && in_axis && ring_stat.limit)
              || is_confirm;
    fire       = in_v_r && (!has_result || !out_v_r || out_ready);
    in_ready   = !in_v_r || fire;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else if (in_valid && in_ready) in_v_r <= 1'b1;
    else if (fire) in_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req_type;
      pen_r <= in_pen_down;
      smp_r <= in_sample;
    end
  end

  // ring for the axis being collected
  always_comb begin
    ring_ctl.clear = fire && is_start && pen_r;
    ring_ctl.step  = fire && is_sample && in_axis;
    ring_ctl.smp   = tsqm_pkg::SAMPLE_BITS'(smp_r);
  end

  tsqm_ring_qual u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ring_ctl),
    .tolerance (tol_r),
    .stat      (ring_stat)
  );

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (is_start) begin
        phase_nxt = pen_r ? tsqm_pkg::PH_X : tsqm_pkg::PH_IDLE;
      end else if (is_sample && in_axis) begin
        if (ring_stat.limit) phase_nxt = tsqm_pkg::PH_IDLE;
        else if (ring_stat.pass) begin
          phase_nxt = (phase_r == tsqm_pkg::PH_X) ? tsqm_pkg::PH_Y : tsqm_pkg::PH_CONFIRM;
        end
      end else if (is_confirm) begin
        phase_nxt = tsqm_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tsqm_pkg::PH_IDLE;
      xavg_r  <= '0;
      yavg_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (ring_ctl.step && !ring_stat.limit && ring_stat.pass) begin
        if (phase_r == tsqm_pkg::PH_X) xavg_r <= ring_stat.avg;
        else yavg_r <= ring_stat.avg;
      end
    end
  end

  // swap and reverse; full-scale minus value is the bitwise complement
  always_comb begin
    vx_sw = orient_r[0] ? yavg_r : xavg_r;
    vy_sw = orient_r[0] ? xavg_r : yavg_r;
    vx    = orient_r[1] ? ~vx_sw : vx_sw;
    vy    = orient_r[2] ? ~vy_sw : vy_sw;
  end

  tsqm_axis_map u_map_x (
    .raw    (vx),
    .scale  (xscale_r),
    .offset (xoff_r),
    .pixels (width_r),
    .pos    (xpos_map)
  );

  tsqm_axis_map u_map_y (
    .raw    (vy),
    .scale  (yscale_r),
    .offset (yoff_r),
    .pixels (height_r),
    .pos    (ypos_map)
  );

  // result payload: a mapped touch or an all-zero failure
  always_comb begin
    map_ok      = is_confirm && pen_r;
    touched_nxt = map_ok;
    xpos_nxt    = map_ok ? xpos_map : '0;
    ypos_nxt    = map_ok ? ypos_map : '0;
    rawx_nxt    = map_ok ? tsqm_pkg::POS_W'(vx) : '0;
    rawy_nxt    = map_ok ? tsqm_pkg::POS_W'(vy) : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (fire && has_result) out_v_r <= 1'b1;
    else if (out_ready) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      touched_r <= touched_nxt;
      xpos_r    <= xpos_nxt;
      ypos_r    <= ypos_nxt;
      rawx_r    <= rawx_nxt;
      rawy_r    <= rawy_nxt;
    end
  end

  assign out_valid   = out_v_r;
  assign out_touched = touched_r;
  assign out_x_pos   = xpos_r;
  assign out_y_pos   = ypos_r;
  assign out_raw_x   = rawx_r;
  assign out_raw_y   = rawy_r;

  // checks
  `TSQM_ASSERT_NXT(a_confirm_to_idle, fire && is_confirm, phase_r == tsqm_pkg::PH_IDLE, "confirm item did not return to idle")
  `TSQM_ASSERT_NXT(a_pass_advances, ring_ctl.step && ring_stat.pass && !ring_stat.limit, (phase_r == tsqm_pkg::PH_Y) || (phase_r == tsqm_pkg::PH_CONFIRM), "qualified axis did not advance")
  `TSQM_ASSERT_IMP(a_fail_zero, out_v_r && !touched_r, (xpos_r == '0) && (ypos_r == '0) && (rawx_r == '0) && (rawy_r == '0), "failure result carries nonzero fields")
  `TSQM_ASSERT_IMP(a_stall_cause, in_v_r && !in_ready, out_v_r && !out_ready && has_result, "input stalled without a waiting result")

endmodule
